/* sv/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

/* sv/sst_pkg.sv */
package sst_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 1024;
    localparam int unsigned ADDR_W = 10;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned CMP_W = 19;
    localparam logic [CMP_W-1:0] CMP_MAX = {CMP_W{1'b1}};

    typedef enum logic [2:0]
    {
        KIND_WRITE  = 3'd0,
        KIND_READ   = 3'd1,
        KIND_SORT   = 3'd2,
        KIND_LINEAR = 3'd3,
        KIND_BINARY = 3'd4
    } kind_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_POP,
        ST_PIV_RD,
        ST_PIV_WT,
        ST_J_RD,
        ST_J_WT,
        ST_SW_RD,
        ST_SW_WT,
        ST_SW_WR,
        ST_FIN_RD,
        ST_FIN_WT,
        ST_FIN_WR,
        ST_PUSH,
        ST_SRCH_RD,
        ST_SRCH_WT,
        ST_DONE
    } state_t;

    typedef enum logic [3:0]
    {
        CMD_NONE,
        CMD_LOAD,
        CMD_WRITE,
        CMD_READ,
        CMD_POP,
        CMD_PIV_RD,
        CMD_PIV_LATCH,
        CMD_J_RD,
        CMD_J_STEP,
        CMD_SW_RD,
        CMD_SW_WR,
        CMD_FIN_RD,
        CMD_FIN_WR,
        CMD_PUSH,
        CMD_SRCH_RD,
        CMD_SRCH_STEP
    } cmd_t;

    typedef struct packed
    {
        cmd_t cmd;
        logic finish;
    } ctrl_t;

    typedef struct packed
    {
        logic [2:0] kind;
        logic       sort_run;
        logic       srch_run;
        logic       stack_empty;
        logic       j_at_end;
        logic       j_swap;
        logic       srch_done;
        logic       push_more;
    } stat_t;

endpackage

/* sv/sst_datapath.sv */
module sst_datapath
    import sst_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ctrl_t                    ctrl,
    output stat_t                    stat,
    input  logic [2:0]               in_kind,
    input  logic [ADDR_W-1:0]        in_low,
    input  logic [ADDR_W-1:0]        in_high,
    input  logic signed [DATA_W-1:0] in_value,
    output logic                     res_found,
    output logic [ADDR_W-1:0]        res_position,
    output logic signed [DATA_W-1:0] res_data,
    output logic [CMP_W-1:0]         res_compares
);

    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned XW = IW + 2;
    localparam int unsigned SPW = $clog2(TABLE_DEPTH + 1);
    localparam logic signed [XW-1:0] LAST = XW'(TABLE_DEPTH - 1);

    logic signed [DATA_W-1:0] mem [TABLE_DEPTH];
    logic [2*IW-1:0]          stk [TABLE_DEPTH];

    logic signed [DATA_W-1:0] rd_reg;
    logic [2*IW-1:0]          stk_rd_reg;
    logic [2:0]               kind_reg;
    logic [ADDR_W-1:0]        lo_in_reg;
    logic signed [DATA_W-1:0] key_reg;
    logic signed [DATA_W-1:0] piv_reg;
    logic signed [DATA_W-1:0] aval_reg;
    logic signed [XW-1:0]     a_reg, b_reg, i_reg, j_reg;
    logic signed [XW-1:0]     sa_reg, sb_reg;
    logic [SPW-1:0]           sp_reg;
    logic [1:0]               pcnt_reg;
    logic [CMP_W-1:0]         cmp_reg;
    logic                     found_reg;
    logic [ADDR_W-1:0]        pos_reg;
    logic signed [DATA_W-1:0] data_reg;

    logic signed [XW-1:0] hi_cl, mid, p, lsz, rsz;
    logic [IW-1:0]        addr;
    logic signed [DATA_W-1:0] wdata;
    logic                 we;
    logic [CMP_W-1:0]     cmp_inc;
    logic signed [XW-1:0] pa, pb;

    assign hi_cl = ($signed({2'b00, in_high}) > LAST) ? LAST : XW'($signed({2'b00, in_high}));
    assign mid = (a_reg + b_reg) >>> 1;
    assign p = i_reg + XW'(1);
    assign lsz = p - XW'(1) - sa_reg;
    assign rsz = sb_reg - p - XW'(1);
    assign cmp_inc = (cmp_reg == CMP_MAX) ? cmp_reg : cmp_reg + CMP_W'(1);

    always_comb
    begin
        pa = sa_reg;
        pb = p - XW'(1);
        if ((lsz > rsz) == (pcnt_reg == 2'd0))
        begin
            pa = sa_reg;
            pb = p - XW'(1);
        end
        else
        begin
            pa = p + XW'(1);
            pb = sb_reg;
        end
    end

    always_comb
    begin
        addr = a_reg[IW-1:0];
        we = 1'b0;
        wdata = key_reg;
        case (ctrl.cmd)
            CMD_WRITE:     begin addr = lo_in_reg[IW-1:0]; we = found_reg; wdata = key_reg; end
            CMD_READ:      addr = lo_in_reg[IW-1:0];
            CMD_PIV_RD:    addr = (pcnt_reg == 2'd3) ? stk_rd_reg[IW-1:0] : sb_reg[IW-1:0];
            CMD_J_RD:      addr = j_reg[IW-1:0];
            CMD_SW_RD:     addr = i_reg[IW-1:0];
            CMD_SW_WR:     begin addr = j_reg[IW-1:0]; we = 1'b1; wdata = rd_reg; end
            CMD_FIN_RD:    addr = p[IW-1:0];
            CMD_FIN_WR:    begin addr = sb_reg[IW-1:0]; we = 1'b1; wdata = rd_reg; end
            CMD_SRCH_RD:   addr = (kind_reg == KIND_BINARY) ? mid[IW-1:0] : a_reg[IW-1:0];
            default:       addr = a_reg[IW-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rd_reg <= mem[addr];
        if (ctrl.cmd == CMD_SW_WR)
        begin
            mem[i_reg[IW-1:0]] <= aval_reg;
        end
        if (ctrl.cmd == CMD_FIN_WR)
        begin
            mem[p[IW-1:0]] <= piv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.cmd == CMD_PUSH && pa < pb && sp_reg < SPW'(TABLE_DEPTH))
        begin
            stk[sp_reg[IW-1:0]] <= {pa[IW-1:0], pb[IW-1:0]};
        end
        if (ctrl.cmd == CMD_POP)
        begin
            stk_rd_reg <= stk[IW'(sp_reg - SPW'(1))];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
            pcnt_reg <= '0;
            kind_reg <= '0;
        end
        else
        begin
            case (ctrl.cmd)
                CMD_LOAD:
                begin
                    kind_reg <= in_kind;
                    lo_in_reg <= in_low;
                    key_reg <= in_value;
                    cmp_reg <= '0;
                    found_reg <= 1'b0;
                    pos_reg <= '0;
                    data_reg <= '0;
                    a_reg <= XW'($signed({2'b00, in_low}));
                    b_reg <= hi_cl;
                    sa_reg <= XW'($signed({2'b00, in_low}));
                    sb_reg <= hi_cl;
                    sp_reg <= '0;
                    pcnt_reg <= 2'd2;
                    if (in_kind == KIND_WRITE || in_kind == KIND_READ)
                    begin
                        pos_reg <= in_low;
                        found_reg <= ({22'd0, in_low} < 32'(TABLE_DEPTH));
                    end
                    if (in_kind == KIND_SORT)
                    begin
                        found_reg <= 1'b1;
                        pos_reg <= in_low;
                    end
                end
                CMD_READ:
                begin
                    pcnt_reg <= 2'd1;
                end
                CMD_POP:
                begin
                    sp_reg <= sp_reg - SPW'(1);
                    pcnt_reg <= 2'd3;
                end
                CMD_PIV_RD:
                begin
                    if (pcnt_reg == 2'd3)
                    begin
                        sa_reg <= XW'($signed({2'b00, stk_rd_reg[2*IW-1:IW]}));
                        sb_reg <= XW'($signed({2'b00, stk_rd_reg[IW-1:0]}));
                    end
                end
                CMD_PIV_LATCH:
                begin
                    piv_reg <= rd_reg;
                    i_reg <= sa_reg - XW'(1);
                    j_reg <= sa_reg;
                end
                CMD_J_STEP:
                begin
                    cmp_reg <= cmp_inc;
                    aval_reg <= rd_reg;
                    if (rd_reg <= piv_reg)
                    begin
                        i_reg <= i_reg + XW'(1);
                    end
                    if (!stat.j_swap)
                    begin
                        j_reg <= j_reg + XW'(1);
                    end
                end
                CMD_SW_WR:
                begin
                    j_reg <= j_reg + XW'(1);
                end
                CMD_FIN_WR:
                begin
                    pcnt_reg <= 2'd0;
                end
                CMD_PUSH:
                begin
                    if (pa < pb && sp_reg < SPW'(TABLE_DEPTH))
                    begin
                        sp_reg <= sp_reg + SPW'(1);
                    end
                    pcnt_reg <= pcnt_reg + 2'd1;
                end
                CMD_SRCH_STEP:
                begin
                    cmp_reg <= cmp_inc;
                    if (rd_reg == key_reg)
                    begin
                        found_reg <= 1'b1;
                        data_reg <= key_reg;
                        pos_reg <= (kind_reg == KIND_BINARY) ? mid[ADDR_W-1:0]
                                                             : a_reg[ADDR_W-1:0];
                        a_reg <= b_reg + XW'(1);
                    end
                    else if (kind_reg == KIND_BINARY)
                    begin
                        if (key_reg > rd_reg)
                        begin
                            a_reg <= mid + XW'(1);
                        end
                        else
                        begin
                            b_reg <= mid - XW'(1);
                        end
                    end
                    else
                    begin
                        a_reg <= a_reg + XW'(1);
                    end
                end
                default:
                begin
                end
            endcase
            if (ctrl.finish && kind_reg == KIND_READ && found_reg)
            begin
                data_reg <= rd_reg;
            end
        end
    end

    always_comb
    begin
        stat.kind = kind_reg;
        stat.sort_run = (kind_reg == KIND_SORT) && (sa_reg < sb_reg);
        stat.srch_run = (a_reg <= b_reg);
        stat.stack_empty = (sp_reg == '0);
        stat.j_at_end = (j_reg >= sb_reg);
        stat.j_swap = (rd_reg <= piv_reg) && (i_reg + XW'(1) != j_reg);
        stat.srch_done = (rd_reg == key_reg) || !(a_reg <= b_reg);
        stat.push_more = (pcnt_reg == 2'd0);
    end

    assign res_found = found_reg;
    assign res_position = pos_reg;
    assign res_data = data_reg;
    assign res_compares = cmp_reg;

endmodule

/* sv/sst_ctrl.sv */
module sst_ctrl
    import sst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic [2:0] in_kind,
    input  logic       out_free,
    input  stat_t      stat,
    output ctrl_t      ctrl,
    output logic       busy,
    output logic       done
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl.cmd = CMD_NONE;
        ctrl.finish = 1'b0;
        busy = (state_reg != ST_IDLE);
        done = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    ctrl.cmd = CMD_LOAD;
                    case (in_kind)
                        KIND_SORT:   state_next = ST_PIV_RD;
                        KIND_LINEAR: state_next = ST_SRCH_RD;
                        KIND_BINARY: state_next = ST_SRCH_RD;
                        default:     state_next = ST_SW_RD;
                    endcase
                end
            end
            ST_SW_RD:
            begin
                if (stat.kind == KIND_WRITE)
                begin
                    ctrl.cmd = CMD_WRITE;
                end
                else
                begin
                    ctrl.cmd = CMD_READ;
                end
                state_next = ST_FIN_WT;
            end
            ST_FIN_WT:
            begin
                ctrl.finish = 1'b1;
                state_next = ST_DONE;
            end
            ST_PIV_RD:
            begin
                if (!stat.sort_run && stat.stack_empty)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ctrl.cmd = CMD_PIV_RD;
                    state_next = ST_PIV_WT;
                end
            end
            ST_PIV_WT:
            begin
                ctrl.cmd = CMD_PIV_LATCH;
                state_next = ST_J_RD;
            end
            ST_J_RD:
            begin
                if (stat.j_at_end)
                begin
                    ctrl.cmd = CMD_FIN_RD;
                    state_next = ST_FIN_RD;
                end
                else
                begin
                    ctrl.cmd = CMD_J_RD;
                    state_next = ST_J_WT;
                end
            end
            ST_J_WT:
            begin
                ctrl.cmd = CMD_J_STEP;
                state_next = stat.j_swap ? ST_SW_WT : ST_J_RD;
            end
            ST_SW_WT:
            begin
                ctrl.cmd = CMD_SW_RD;
                state_next = ST_SW_WR;
            end
            ST_SW_WR:
            begin
                ctrl.cmd = CMD_SW_WR;
                state_next = ST_J_RD;
            end
            ST_FIN_RD:
            begin
                ctrl.cmd = CMD_FIN_WR;
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                ctrl.cmd = CMD_PUSH;
                if (!stat.push_more)
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                if (stat.stack_empty)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ctrl.cmd = CMD_POP;
                    state_next = ST_FIN_WR;
                end
            end
            ST_FIN_WR:
            begin
                state_next = ST_PIV_RD;
            end
            ST_SRCH_RD:
            begin
                if (!stat.srch_run)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ctrl.cmd = CMD_SRCH_RD;
                    state_next = ST_SRCH_WT;
                end
            end
            ST_SRCH_WT:
            begin
                ctrl.cmd = CMD_SRCH_STEP;
                state_next = ST_SRCH_RD;
            end
            ST_DONE:
            begin
                done = 1'b1;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/sort_and_search_table.sv */
// Channel   | Beat fields (tdata from bit 0)                       | Notes
// s_axis    | kind[2:0] range_low[12:3] range_high[22:13] value    | value at [54:23]
// m_axis    | found[0] position[10:1] data_word[42:11] compares    | compares at [61:43]
// One item is taken at a time; a write or a read makes a single table access.
// A linear search reads and compares one entry per probe, and so does a binary search.
// A sort compares each entry with the pivot, swaps where needed, then places the pivot.
// The result waits in an output register; a new item is taken once the result is placed in it.
// Reset clears control state only; table entries are undefined until written.
module sort_and_search_table
    import sst_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // kind, range_low, range_high, item_value, pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // found, position, data_word, compares, pad
);

    ctrl_t ctrl;
    stat_t stat;
    logic busy, done, out_free, in_fire;
    logic                     r_found;
    logic [ADDR_W-1:0]        r_pos;
    logic signed [DATA_W-1:0] r_data;
    logic [CMP_W-1:0]         r_cmp;
    logic        ovalid_reg;
    logic [63:0] odata_reg;

    assign s_axis_tready = !busy;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_free = !ovalid_reg || m_axis_tready;

    sst_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_kind  (s_axis_tdata[2:0]),
        .out_free (out_free),
        .stat     (stat),
        .ctrl     (ctrl),
        .busy     (busy),
        .done     (done)
    );

    sst_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .in_kind      (s_axis_tdata[2:0]),
        .in_low       (s_axis_tdata[12:3]),
        .in_high      (s_axis_tdata[22:13]),
        .in_value     (s_axis_tdata[54:23]),
        .res_found    (r_found),
        .res_position (r_pos),
        .res_data     (r_data),
        .res_compares (r_cmp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (done && out_free)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done && out_free)
        begin
            odata_reg <= {2'b00, r_cmp, r_data, r_pos, r_found};
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = odata_reg;

endmodule

/* sv/sst_checker.sv */
`include "assert_macros.svh"
module sst_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    `ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
    `ASSERT_NEXT(a_busy, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken during work")
    `ASSERT_IMPL(a_pad, clk, rst_n, m_axis_tvalid, m_axis_tdata[63:62] == 2'b00, "nonzero padding")

endmodule

bind sort_and_search_table sst_checker u_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* sim/tb_sort_and_search_table.sv */
`timescale 1ns / 100ps

module tb_sort_and_search_table;
    import sst_pkg::*;

    localparam int DEPTH = 1024;
    localparam int WATCHDOG_LIMIT = 4000000;

    typedef struct packed
    {
        logic [31:0] item_value;
        logic [9:0]  range_high;
        logic [9:0]  range_low;
        logic [2:0]  kind;
    } op_t;

    typedef struct packed
    {
        logic [18:0] compares;
        logic [31:0] data_word;
        logic [9:0]  position;
        logic        found;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;

    op_t         pending_ops[$];
    answer_t     expected_answers[$];
    logic [31:0] table_copy[DEPTH];
    bit          written[DEPTH];
    int          idle_from;
    int          error_count;
    int          quiet_cycles;
    bit          stimulus_done;
    logic        s_axis_tready_seen;

    sort_and_search_table u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int partition_range(int lo, int hi, ref int cmp);
        logic signed [31:0] pivot;
        logic [31:0] t;
        int i;
        pivot = table_copy[hi];
        i = lo - 1;
        for (int j = lo; j < hi; j++)
        begin
            cmp++;
            if ($signed(table_copy[j]) <= pivot)
            begin
                i++;
                t = table_copy[i];
                table_copy[i] = table_copy[j];
                table_copy[j] = t;
            end
        end
        t = table_copy[i + 1];
        table_copy[i + 1] = table_copy[hi];
        table_copy[hi] = t;
        return i + 1;
    endfunction

    function automatic int quicksort_compares(int lo, int hi);
        int cmp;
        int a;
        int b;
        int p;
        int stack_lo[$];
        int stack_hi[$];
        cmp = 0;
        stack_lo.push_back(lo);
        stack_hi.push_back(hi);
        while (stack_lo.size() > 0)
        begin
            a = stack_lo.pop_back();
            b = stack_hi.pop_back();
            p = partition_range(a, b, cmp);
            if ((p - 1 - a) > (b - p - 1))
            begin
                if (a < p - 1) begin stack_lo.push_back(a); stack_hi.push_back(p - 1); end
                if (p + 1 < b) begin stack_lo.push_back(p + 1); stack_hi.push_back(b); end
            end
            else
            begin
                if (p + 1 < b) begin stack_lo.push_back(p + 1); stack_hi.push_back(b); end
                if (a < p - 1) begin stack_lo.push_back(a); stack_hi.push_back(p - 1); end
            end
        end
        return cmp;
    endfunction

    function automatic answer_t predict_answer(op_t op);
        answer_t r;
        int lo;
        int hi;
        int a;
        int b;
        int mid;
        int cmp;
        logic signed [31:0] key;
        r = '0;
        cmp = 0;
        lo = op.range_low;
        hi = op.range_high;
        key = op.item_value;
        case (op.kind)
            KIND_WRITE:
            begin
                table_copy[lo] = op.item_value;
                written[lo] = 1'b1;
                r.found = 1'b1;
                r.position = op.range_low;
            end
            KIND_READ:
            begin
                r.found = 1'b1;
                r.position = op.range_low;
                r.data_word = table_copy[lo];
            end
            KIND_SORT:
            begin
                r.found = 1'b1;
                r.position = op.range_low;
                if (lo < hi)
                    cmp = quicksort_compares(lo, hi);
            end
            KIND_LINEAR:
            begin
                for (int i = lo; i <= hi; i++)
                begin
                    cmp++;
                    if ($signed(table_copy[i]) == key)
                    begin
                        r.found = 1'b1;
                        r.position = 10'(i);
                        r.data_word = key;
                        break;
                    end
                end
            end
            KIND_BINARY:
            begin
                a = lo;
                b = hi;
                while (a <= b)
                begin
                    mid = (a + b) / 2;
                    cmp++;
                    if (key == $signed(table_copy[mid]))
                    begin
                        r.found = 1'b1;
                        r.position = 10'(mid);
                        r.data_word = key;
                        break;
                    end
                    else if (key > $signed(table_copy[mid]))
                        a = mid + 1;
                    else
                        b = mid - 1;
                end
            end
            default: ;
        endcase
        r.compares = (cmp > int'(CMP_MAX)) ? CMP_MAX : cmp[18:0];
        return r;
    endfunction

    function automatic op_t make_op(logic [2:0] kind, int lo, int hi, logic [31:0] value);
        op_t op;
        op.kind = kind;
        op.range_low = lo[9:0];
        op.range_high = hi[9:0];
        op.item_value = value;
        return op;
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 15) - 8;
            1: return 32'h8000_0000 ^ $urandom_range(0, 3);
            2: return 32'h7fff_ffff - $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    // Fills a small window with values, then sorts or searches inside it.
    // Reads and searches only touch entries that have been written.
    task automatic queue_window();
        int base;
        int len;
        int hi;
        int dup;
        base = ($urandom_range(0, 9) == 0) ? DEPTH - 24 + $urandom_range(0, 8)
                                           : $urandom_range(0, DEPTH - 24);
        len = $urandom_range(1, 16);
        hi = base + len - 1;
        dup = $urandom_range(0, 1);
        for (int i = base; i <= hi; i++)
        begin
            if (!written[i] || $urandom_range(0, 1))
            begin
                pending_ops.push_back(make_op(KIND_WRITE, i, 0,
                    dup ? 32'($urandom_range(0, 5)) - 2 : random_value()));
                written[i] = 1'b1;
            end
        end
        if ($urandom_range(0, 3) != 0)
            pending_ops.push_back(make_op(KIND_SORT, base, hi, $urandom()));
        repeat ($urandom_range(1, 3))
        begin
            pending_ops.push_back(make_op($urandom_range(0, 1) ? KIND_BINARY : KIND_LINEAR,
                base + $urandom_range(0, len - 1), hi,
                $urandom_range(0, 1) ? random_value() : 32'($urandom_range(0, 5)) - 2));
        end
        pending_ops.push_back(make_op(KIND_READ, base + $urandom_range(0, len - 1),
                                      $urandom(), $urandom()));
        if ($urandom_range(0, 7) == 0)
            pending_ops.push_back(make_op(3'($urandom_range(5, 7)), $urandom(), $urandom(),
                                          $urandom()));
        if ($urandom_range(0, 7) == 0)
            pending_ops.push_back(make_op(3'($urandom_range(2, 4)), hi, base - 1 + (base == 0),
                                          random_value()));
    endtask

    initial
    begin
        for (int i = 0; i < 12; i++)
        begin
            pending_ops.push_back(make_op(KIND_WRITE, i, 1023, 32'(11 - i) * 32'h1234_5679));
            written[i] = 1'b1;
        end
        pending_ops.push_back(make_op(KIND_WRITE, 1023, 0, 32'h7fff_ffff));
        pending_ops.push_back(make_op(KIND_WRITE, 1022, 0, 32'h8000_0000));
        pending_ops.push_back(make_op(KIND_WRITE, 1021, 0, 32'hffff_ffff));
        written[1023] = 1'b1;
        written[1022] = 1'b1;
        written[1021] = 1'b1;
        pending_ops.push_back(make_op(KIND_READ, 1023, 0, 0));
        pending_ops.push_back(make_op(KIND_BINARY, 0, 11, 32'h1234_5679));
        pending_ops.push_back(make_op(KIND_LINEAR, 0, 11, 32'h1234_5679));
        pending_ops.push_back(make_op(KIND_SORT, 0, 11, 0));
        pending_ops.push_back(make_op(KIND_BINARY, 0, 11, 32'h1234_5679));
        pending_ops.push_back(make_op(KIND_LINEAR, 1021, 1023, 32'h5555_5555));
        pending_ops.push_back(make_op(KIND_SORT, 1021, 1023, 0));
        pending_ops.push_back(make_op(KIND_READ, 1021, 0, 0));
        pending_ops.push_back(make_op(KIND_SORT, 5, 4, 0));
        pending_ops.push_back(make_op(KIND_LINEAR, 7, 3, 0));
        pending_ops.push_back(make_op(3'd7, 1023, 1023, 32'hffff_ffff));
        pending_ops.push_back(make_op(3'd5, 0, 0, 0));
        while (pending_ops.size() < 575)
            queue_window();
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
        begin
            idle_from <= $urandom_range(0, 3000);
        end
    end

    function automatic bit take_pause();
        return ($urandom_range(0, 99) < 18) && !(quiet_cycles >= 0 && idle_from > 2000);
    endfunction

    initial s_axis_tready_seen = 1'b0;

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= !take_pause();
            if (!s_axis_tvalid || s_axis_tready_seen)
            begin
                if (pending_ops.size() > 0 && !take_pause())
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {1'b0, pending_ops.pop_front()};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        s_axis_tready_seen <= 1'b0;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            s_axis_tready_seen <= 1'b1;
            expected_answers.push_back(predict_answer(op_t'(s_axis_tdata[54:0])));
        end
    end

    always @(posedge clk)
    begin
        answer_t got;
        answer_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = answer_t'(m_axis_tdata[61:0]);
            if (expected_answers.size() == 0)
            begin
                $error("unexpected result beat %h", got);
                error_count++;
            end
            else
            begin
                want = expected_answers.pop_front();
                if (got.found !== want.found)
                begin
                    $error("found: expected %0d, actual %0d", want.found, got.found);
                    error_count++;
                end
                if (got.position !== want.position)
                begin
                    $error("position: expected %0d, actual %0d", want.position, got.position);
                    error_count++;
                end
                if (got.data_word !== want.data_word)
                begin
                    $error("data_word: expected %h, actual %h", want.data_word, got.data_word);
                    error_count++;
                end
                if (got.compares !== want.compares)
                begin
                    $error("compares: expected %0d, actual %0d", want.compares, got.compares);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        idle_from = 0;
        error_count = 0;
        quiet_cycles = 0;
        stimulus_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("sort_and_search_table: mismatch");
                $finish;
            end
            if (!stimulus_done && pending_ops.size() == 0 && !s_axis_tvalid
                && expected_answers.size() == 0)
            begin
                stimulus_done = 1'b1;
                repeat (100) @(posedge clk);
                if (error_count == 0 && expected_answers.size() == 0 && !m_axis_tvalid)
                    $display("sort_and_search_table: match");
                else
                    $display("sort_and_search_table: mismatch");
                $finish;
            end
        end
    end

endmodule

/* sim.f */
+incdir+sv
sv/sst_pkg.sv
sv/sst_datapath.sv
sv/sst_ctrl.sv
sv/sort_and_search_table.sv
sv/sst_checker.sv
sim/tb_sort_and_search_table.sv
